@@ src/tpr_pkg.sv @@
// texture prefetch ranker: shared constants, codes and types
// no dependencies; imported by every module of the block
package tpr_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int WINDOW_MAX    = 32;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int LEN_W   = HIST_AW + 1;
  localparam int POS_W   = HIST_AW + 1;
  localparam int MEM_AW  = HIST_AW + 1;
  localparam int WIN_CW  = $clog2(WINDOW_MAX + 1);
  localparam int WIN_IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int POS_MAX = 2 * HISTORY_DEPTH - 1;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_FRAME  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NA    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RK_IDLE,
    RK_READ,
    RK_DRAIN,
    RK_SCAN,
    RK_EMIT
  } rank_state_t;

  typedef struct packed {
    logic              start;
    logic [WIN_CW-1:0] count;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              bank;
    logic              ovf;
  } query_cmd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

endpackage

@@ src/tpr_if.sv @@
// texture prefetch ranker: request and result channel interfaces
// depends on nothing; field widths are fixed by the channel format
interface tpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] texture_id;
  logic [5:0]  query_count;

  modport source (output valid, req_type, texture_id, query_count, input ready);
  modport sink   (input valid, req_type, texture_id, query_count, output ready);
endinterface

interface tpr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ranked_id;
  logic [15:0] rank_weight;
  logic [1:0]  status;
  logic        last_of_run;
  logic        history_overflow;

  modport source (output valid, ranked_id, rank_weight, status, last_of_run,
                  history_overflow, input ready);
  modport sink   (input valid, ranked_id, rank_weight, status, last_of_run,
                  history_overflow, output ready);
endinterface

@@ src/tpr_hist_mem.sv @@
// texture prefetch ranker: two-bank history memory, one write and one read port
// depends on tpr_pkg; read data registered
module tpr_hist_mem
  import tpr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [MEM_AW-1:0] waddr,
  input  logic [31:0]       wdata,
  input  mem_rd_t           rd,
  output logic [31:0]       rdata
);

  logic [31:0] mem [2**MEM_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

@@ src/tpr_rank.sv @@
// texture prefetch ranker: query engine (window read, distinct count, ranked emit)
// depends on tpr_pkg, tpr_if; reads the history memory through a registered read port
module tpr_rank
  import tpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  query_cmd_t  cmd,
  output logic        busy,
  output mem_rd_t     rd,
  input  logic [31:0] rd_data,
  tpr_out_if.source   out_ch
);

  rank_state_t state_r, state_nxt;

  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic              bank_r;
  logic              ovf_r;
  logic [WIN_CW-1:0] cnt_r;
  logic [WIN_CW-1:0] i_r;
  logic              rdv_r;
  logic [WIN_CW-1:0] ndist_r;
  logic [31:0]       ids_r  [WINDOW_MAX];
  logic [WIN_CW-1:0] cnts_r [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] done_r;
  logic [WIN_IW-1:0] j_r;
  logic [WIN_IW-1:0] best_r;
  logic [15:0]       best_w_r;
  logic              have_r;
  logic [WIN_CW-1:0] emitted_r;

  logic        out_valid_r;
  logic [31:0] out_id_r;
  logic [15:0] out_w_r;
  status_t     out_st_r;
  logic        out_last_r;
  logic        out_ovf_r;

  // start checks
  logic [POS_W+WIN_CW:0] win_end;
  logic                  q_na, q_empty;
  logic [WIN_CW-1:0]     last_i;
  logic                  slot_free;

  always_comb begin
    win_end = (POS_W+WIN_CW+1)'(cmd.pos) + (POS_W+WIN_CW+1)'(cmd.count);
    q_na    = (cmd.pos > cmd.len) ||
              ((cmd.count != '0) &&
               ((cmd.len == '0) ||
                (win_end > ((POS_W+WIN_CW+1)'(cmd.len) << 1))));
    q_empty = (cmd.count == '0);
    last_i  = cnt_r - WIN_CW'(1);
    slot_free = !out_valid_r || out_ch.ready;
  end

  // window address with one wrap
  logic [POS_W:0] idx;
  logic [POS_W:0] off;
  always_comb begin
    idx = (POS_W+1)'(pos_r) + (POS_W+1)'(i_r);
    off = (idx >= (POS_W+1)'(len_r)) ? idx - (POS_W+1)'(len_r) : idx;
  end

  // parallel match against the distinct table
  logic [WINDOW_MAX-1:0] hit;
  always_comb begin
    for (int k = 0; k < WINDOW_MAX; k++) begin
      hit[k] = (WIN_CW'(k) < ndist_r) && (ids_r[k] == rd_data);
    end
  end

  // weight of the entry under the scan pointer
  logic [WIN_CW-1:0]   rank_rev;
  logic [2*WIN_CW-1:0] prod;
  logic [15:0]         w_j;
  logic                take;
  logic                scan_end;
  always_comb begin
    rank_rev = ndist_r - WIN_CW'(j_r);
    prod     = rank_rev * cnts_r[j_r];
    w_j      = 16'(prod);
    take     = !done_r[j_r] && (!have_r || (w_j > best_w_r));
    scan_end = (WIN_CW'(j_r) == ndist_r - WIN_CW'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RK_IDLE: begin
        if (cmd.start && !q_na && !q_empty) state_nxt = RK_READ;
      end
      RK_READ: begin
        if (i_r == last_i) state_nxt = RK_DRAIN;
      end
      RK_DRAIN: state_nxt = RK_SCAN;
      RK_SCAN: begin
        if (scan_end) state_nxt = RK_EMIT;
      end
      RK_EMIT: begin
        if (slot_free) begin
          state_nxt = (emitted_r + WIN_CW'(1) == ndist_r) ? RK_IDLE : RK_SCAN;
        end
      end
      default: state_nxt = RK_IDLE;
    endcase
  end

  // outputs of the state machine
  logic load_status, load_rank;
  always_comb begin
    rd.en       = 1'b0;
    rd.addr     = {bank_r, off[HIST_AW-1:0]};
    load_status = 1'b0;
    load_rank   = 1'b0;
    case (state_r)
      RK_IDLE: load_status = cmd.start && (q_na || q_empty);
      RK_READ: rd.en = 1'b1;
      RK_EMIT: load_rank = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RK_IDLE;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rd.en;
      if (load_status || load_rank) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == RK_IDLE && cmd.start) begin
      pos_r   <= cmd.pos;
      len_r   <= cmd.len;
      bank_r  <= cmd.bank;
      ovf_r   <= cmd.ovf;
      cnt_r   <= cmd.count;
      i_r     <= '0;
      ndist_r <= '0;
      done_r  <= '0;
    end
    if (state_r == RK_READ) begin
      i_r <= i_r + WIN_CW'(1);
    end
    // table update on each returning id
    if (rdv_r) begin
      if (hit != '0) begin
        for (int k = 0; k < WINDOW_MAX; k++) begin
          if (hit[k]) cnts_r[k] <= cnts_r[k] + WIN_CW'(1);
        end
      end else begin
        ids_r[ndist_r[WIN_IW-1:0]]  <= rd_data;
        cnts_r[ndist_r[WIN_IW-1:0]] <= WIN_CW'(1);
        ndist_r <= ndist_r + WIN_CW'(1);
      end
    end
    if (state_r == RK_DRAIN) begin
      j_r       <= '0;
      have_r    <= 1'b0;
      emitted_r <= '0;
    end
    if (state_r == RK_SCAN) begin
      if (take) begin
        best_r   <= j_r;
        best_w_r <= w_j;
        have_r   <= 1'b1;
      end
      if (!scan_end) j_r <= j_r + WIN_IW'(1);
    end
    if (load_rank) begin
      done_r[best_r] <= 1'b1;
      emitted_r      <= emitted_r + WIN_CW'(1);
      j_r            <= '0;
      have_r         <= 1'b0;
      out_id_r       <= ids_r[best_r];
      out_w_r        <= best_w_r;
      out_st_r       <= ST_VALID;
      out_last_r     <= (emitted_r + WIN_CW'(1) == ndist_r);
      out_ovf_r      <= ovf_r;
    end
    if (load_status) begin
      out_id_r   <= '0;
      out_w_r    <= '0;
      out_st_r   <= q_na ? ST_NA : ST_EMPTY;
      out_last_r <= 1'b1;
      out_ovf_r  <= cmd.ovf;
    end
  end

  assign busy                    = (state_r != RK_IDLE) || out_valid_r;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.ranked_id        = out_id_r;
  assign out_ch.rank_weight      = out_w_r;
  assign out_ch.status           = out_st_r;
  assign out_ch.last_of_run      = out_last_r;
  assign out_ch.history_overflow = out_ovf_r;

  // a ranked result never appears while ids are still being collected
  a_no_emit_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RK_READ) |-> !load_rank)
    else $error("ranked result during window read");

  // distinct count never exceeds the window
  a_ndist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RK_SCAN) |-> (ndist_r <= cnt_r))
    else $error("distinct count above window");

  // a scan only runs over a nonempty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == RK_SCAN) |-> (ndist_r != '0))
    else $error("scan over empty table");

endmodule

@@ src/texture_prefetch_ranker_core.sv @@
// texture prefetch ranker: top level, history bookkeeping and request decode
// depends on tpr_pkg, tpr_if, tpr_hist_mem, tpr_rank
//
//   channel   dir  fields
//   in_ch     in   req_type[1:0], texture_id[31:0], query_count[5:0]
//   out_ch    out  ranked_id[31:0], rank_weight[15:0], status[1:0],
//                  last_of_run, history_overflow
//
// record and frame transactions are accepted back to back while no query is busy
// a query holds in_ch.ready low while it runs: one memory read per window slot,
//   then one table scan per ranked id, until its last result has left out_ch
// a status answer (empty or not available) is registered from idle, with no memory read
// output stalls hold the query engine before each emit; reset is synchronous, active low
module texture_prefetch_ranker_core
  import tpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tpr_in_if.sink    in_ch,
  tpr_out_if.source out_ch
);

  logic             bank_r;
  logic [LEN_W-1:0] len_r [2];
  logic [POS_W-1:0] pos_r;
  logic             ovf_r;

  logic        rank_busy;
  logic        in_acc;
  logic        rec, frm, qry;
  logic        has_room;
  query_cmd_t  cmd;
  mem_rd_t     rd;
  logic [31:0] rd_data;

  always_comb begin
    in_acc   = in_ch.valid && in_ch.ready;
    rec      = in_acc && (req_t'(in_ch.req_type) == REQ_RECORD);
    frm      = in_acc && (req_t'(in_ch.req_type) == REQ_FRAME);
    qry      = in_acc && (req_t'(in_ch.req_type) == REQ_QUERY);
    has_room = (len_r[bank_r] < LEN_W'(HISTORY_DEPTH));

    cmd.start = qry;
    if (32'(in_ch.query_count) > 32'(WINDOW_MAX)) begin
      cmd.count = WIN_CW'(WINDOW_MAX);
    end else begin
      cmd.count = WIN_CW'(in_ch.query_count);
    end
    cmd.pos  = pos_r;
    cmd.len  = len_r[~bank_r];
    cmd.bank = ~bank_r;
    cmd.ovf  = ovf_r;
  end

  assign in_ch.ready = !rank_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      len_r[0] <= '0;
      len_r[1] <= '0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (rec) begin
      if (has_room) begin
        len_r[bank_r] <= len_r[bank_r] + LEN_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
      if (pos_r < POS_W'(POS_MAX)) pos_r <= pos_r + POS_W'(1);
    end else if (frm) begin
      bank_r         <= ~bank_r;
      len_r[~bank_r] <= '0;
      pos_r          <= '0;
      ovf_r          <= 1'b0;
    end
  end

  // writes happen only on records, reads only inside a query: no overlap
  tpr_hist_mem u_mem (
    .clk   (clk),
    .we    (rec && has_room),
    .waddr ({bank_r, len_r[bank_r][HIST_AW-1:0]}),
    .wdata (in_ch.texture_id),
    .rd    (rd),
    .rdata (rd_data)
  );

  tpr_rank u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .busy    (rank_busy),
    .rd      (rd),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

  // a query blocks new transactions on the following cycle
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    qry |=> !in_ch.ready)
    else $error("query did not block input");

  // bank lengths stay within the history depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r[0] <= LEN_W'(HISTORY_DEPTH)) && (len_r[1] <= LEN_W'(HISTORY_DEPTH)))
    else $error("bank length above depth");

  // a record never moves the position backward
  a_pos_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rec |=> (pos_r >= $past(pos_r)) && (pos_r != '0))
    else $error("position did not advance");

endmodule

@@ bench/tpr_rank_checker.sv @@
// texture prefetch ranker: transaction monitor, ranking predictor and result compare
// depends on tpr_pkg and the channel interfaces in tpr_if
`timescale 1ns / 100ps
module tpr_rank_checker
  import tpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tpr_in_if    in_ch,
  tpr_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [31:0] id;
    logic [15:0] weight;
    status_t     status;
    logic        last;
    logic        ovf;
  } rank_entry_t;

  rank_entry_t ranks_due[$];

  logic [31:0] hist [2][HISTORY_DEPTH];
  logic        cur_bank;
  int          bank_len [2];
  int          frame_pos;
  logic        ovf_flag;

  function void push_rank(logic [31:0] id, logic [15:0] weight, status_t status,
                          logic last);
    rank_entry_t e;
    e.id     = id;
    e.weight = weight;
    e.status = status;
    e.last   = last;
    e.ovf    = ovf_flag;
    ranks_due.insert(ranks_due.size(), e);
  endfunction

  function void rank_query(logic [5:0] qcount);
    int          prev;
    int          len;
    int          cnt;
    int          nd;
    int          idx;
    int          off;
    int          j;
    int          v;
    logic [31:0] rid;
    logic [31:0] ids [WINDOW_MAX];
    int          hits [WINDOW_MAX];
    int          wt [WINDOW_MAX];
    int          ord [WINDOW_MAX];
    prev = !cur_bank;
    len  = bank_len[prev];
    cnt  = (qcount > WINDOW_MAX) ? WINDOW_MAX : qcount;
    nd   = 0;
    if (frame_pos > len) begin
      push_rank('0, '0, ST_NA, 1'b1);
      return;
    end
    if (cnt == 0) begin
      push_rank('0, '0, ST_EMPTY, 1'b1);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      idx = i + frame_pos;
      off = (idx >= len) ? idx - len : idx;
      if (off >= len || off >= HISTORY_DEPTH) begin
        push_rank('0, '0, ST_NA, 1'b1);
        return;
      end
      rid = hist[prev][off];
      for (j = 0; j < nd; j++)
        if (ids[j] == rid) break;
      if (j < nd) begin
        hits[j]++;
      end else if (nd < WINDOW_MAX) begin
        ids[nd]  = rid;
        hits[nd] = 1;
        nd++;
      end
    end
    for (int i = 0; i < nd; i++) begin
      wt[i]  = ((nd - i) * hits[i]) & 16'hffff;
      ord[i] = i;
    end
    // stable insertion sort, heaviest first
    for (int i = 1; i < nd; i++) begin
      v = ord[i];
      j = i;
      while (j > 0 && wt[ord[j-1]] < wt[v]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    for (int i = 0; i < nd; i++)
      push_rank(ids[ord[i]], wt[ord[i]][15:0], ST_VALID, i + 1 == nd);
  endfunction

  function void apply_request(logic [1:0] kind, logic [31:0] tid, logic [5:0] qcount);
    case (kind)
      REQ_RECORD: begin
        if (bank_len[cur_bank] < HISTORY_DEPTH) begin
          hist[cur_bank][bank_len[cur_bank]] = tid;
          bank_len[cur_bank]++;
        end else begin
          ovf_flag = 1'b1;
        end
        if (frame_pos < POS_MAX) frame_pos++;
      end
      REQ_FRAME: begin
        cur_bank           = !cur_bank;
        bank_len[cur_bank] = 0;
        frame_pos          = 0;
        ovf_flag           = 1'b0;
      end
      REQ_QUERY: rank_query(qcount);
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rank_entry_t e;
    if (!rst_n) begin
      cur_bank    = 1'b0;
      bank_len[0] = 0;
      bank_len[1] = 0;
      frame_pos   = 0;
      ovf_flag    = 1'b0;
      ranks_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_request(in_ch.req_type, in_ch.texture_id, in_ch.query_count);
      if (out_ch.valid && out_ch.ready) begin
        if (ranks_due.size() == 0) begin
          $error("result with nothing expected: id %0h status %0d",
                 out_ch.ranked_id, out_ch.status);
          errors++;
        end else begin
          e = ranks_due.pop_front();
          check_field("ranked_id", e.id, out_ch.ranked_id);
          check_field("rank_weight", e.weight, out_ch.rank_weight);
          check_field("status", e.status, out_ch.status);
          check_field("last_of_run", e.last, out_ch.last_of_run);
          check_field("history_overflow", e.ovf, out_ch.history_overflow);
        end
      end
    end
    pending = ranks_due.size();
  end

endmodule

@@ bench/tb.sv @@
// texture prefetch ranker: stimulus, channel pacing and verdict
// depends on tpr_pkg, tpr_if, texture_prefetch_ranker_core and tpr_rank_checker
`timescale 1ns / 100ps
module tb;
  import tpr_pkg::*;

  logic clk;
  logic rst_n;
  int   n_errors;
  int   n_pending;
  int   n_sent;
  int   idle_pct;
  int   stall_pct;
  int   hold_left;
  logic hold_req;
  logic hold_seen;

  tpr_in_if  in_ch ();
  tpr_out_if out_ch ();

  texture_prefetch_ranker_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tpr_rank_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (n_errors),
    .pending (n_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_seen    = 1'b0;
    hold_left    = 0;
  end

  // long hold-offs are counted here so the sender keeps pushing meanwhile
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_req(req_t kind, logic [31:0] tid, logic [5:0] qcount);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.texture_id  <= tid;
    in_ch.query_count <= qcount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
  endtask

  // one previous frame from a small id pool, then a few look-ahead queries
  task automatic frame_and_queries();
    int          len;
    int          npool;
    int          pos;
    int          q;
    logic [31:0] pool [10];
    len   = $urandom_range(1, 40);
    npool = $urandom_range(1, 10);
    pos   = 0;
    foreach (pool[i]) pool[i] = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
    send_req(REQ_FRAME, $urandom, 6'($urandom));
    repeat (len) send_req(REQ_RECORD, pool[$urandom_range(npool - 1)], 6'($urandom));
    send_req(REQ_FRAME, $urandom, 6'($urandom));
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 3)) begin
        send_req(REQ_RECORD, $urandom, 6'($urandom));
        pos++;
      end
      if ($urandom_range(9) == 0) send_req(REQ_NONE, $urandom, 6'($urandom));
      if ($urandom_range(9) < 2 || pos > len)
        q = $urandom_range(63);
      else
        q = $urandom_range(0, (2 * len - pos > 32) ? 32 : 2 * len - pos);
      send_req(REQ_QUERY, $urandom, 6'(q));
    end
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    hold_req          = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_NONE;
    in_ch.texture_id  = '0;
    in_ch.query_count = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    n_sent            = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty history: not available, empty answer, ignored type; then short frames queried
    send_req(REQ_QUERY, '0, 6'd5);
    send_req(REQ_QUERY, '0, 6'd0);
    send_req(REQ_NONE, 32'hffff_ffff, 6'h3f);
    send_req(REQ_RECORD, 32'h0, '0);
    send_req(REQ_RECORD, 32'hffff_ffff, '0);
    send_req(REQ_RECORD, 32'h0, '0);
    send_req(REQ_RECORD, 32'h5555_aaaa, '0);
    send_req(REQ_FRAME, '0, '0);
    send_req(REQ_QUERY, '0, 6'd0);
    send_req(REQ_QUERY, '0, 6'd1);
    send_req(REQ_QUERY, '0, 6'd4);
    send_req(REQ_QUERY, '0, 6'd8);
    send_req(REQ_QUERY, '0, 6'h3f);
    send_req(REQ_RECORD, 32'haaaa_5555, '0);
    send_req(REQ_QUERY, '0, 6'd4);
    send_req(REQ_QUERY, '0, 6'd7);
    send_req(REQ_RECORD, 32'h1, '0);
    send_req(REQ_RECORD, 32'h2, '0);
    send_req(REQ_RECORD, 32'h3, '0);
    send_req(REQ_RECORD, 32'h4, '0);
    send_req(REQ_QUERY, '0, 6'd1);

    // full window of repeated ids, count above the window
    send_req(REQ_FRAME, '0, '0);
    repeat (40) send_req(REQ_RECORD, $urandom_range(7), '0);
    send_req(REQ_FRAME, '0, '0);
    send_req(REQ_QUERY, '0, 6'd40);
    send_req(REQ_RECORD, $urandom, '0);
    send_req(REQ_QUERY, '0, 6'd32);
    drain_results();
    n_sent = 0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        3: begin idle_pct = 36; stall_pct = 36; end
        default: begin idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
      endcase
      if (ph == 3) begin
        // receiver holds off while queries back up the input
        hold_req = !hold_req;
        frame_and_queries();
        frame_and_queries();
        drain_results();
      end
      while (n_sent < 80 * (ph + 1)) frame_and_queries();
      drain_results();
    end

    repeat (50) @(negedge clk);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
